// ===== hw/rtl/mm_pkg.sv =====
// Shared types, sizes and helper functions for the matrix multiply core.
package mm_pkg;

    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 16;

    // Stored element width: the port carries 16 bits, narrower builds keep the low bits.
    localparam int ELEM_BITS = (ELEM_WIDTH < 16) ? ELEM_WIDTH : 16;
    localparam int FRAC_BITS = 12;

    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W   = 2 * ELEM_BITS + $clog2(MAX_DIM) + 1;

    // Fixed port field widths.
    localparam int PORT_IDX_W = 3;
    localparam int VAL_W      = 16;
    localparam int DIM_W      = 4;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_EMIT
    } t_state;

    // Control tag that travels alongside one multiply-accumulate operand pair.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
        int full;
        full = int'(row) * MAX_DIM + int'(col);
        return ADDR_W'(full);
    endfunction

    // Largest index in use for a dimension register; zero acts as one, large values clamp.
    function automatic logic [IDX_W-1:0] dim_max(input logic [DIM_W-1:0] dim);
        logic [IDX_W-1:0] res;
        if (dim == '0) begin
            res = '0;
        end else if (int'(dim) > MAX_DIM) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(int'(dim) - 1);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/mm_store.sv =====
// Element store: one write port and one registered read port.
module mm_store (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [mm_pkg::ADDR_W-1:0]            i_waddr,
    input  logic signed [mm_pkg::ELEM_BITS-1:0]  i_wdata,
    input  logic [mm_pkg::ADDR_W-1:0]            i_raddr,
    output logic signed [mm_pkg::ELEM_BITS-1:0]  o_rdata
);
    import mm_pkg::*;

    logic signed [ELEM_BITS-1:0] r_mem [DEPTH];
    logic signed [ELEM_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mm_mac.sv =====
// Shared multiply-accumulate unit with rounding and saturation of the sum.
module mm_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mm_pkg::t_mac_ctl                     i_ctl,
    input  logic signed [mm_pkg::ELEM_BITS-1:0]  i_a,
    input  logic signed [mm_pkg::ELEM_BITS-1:0]  i_b,
    output logic                                 o_done,
    output logic signed [mm_pkg::ELEM_BITS-1:0]  o_result
);
    import mm_pkg::*;

    localparam logic signed [ACC_W:0] ROUND_ADD = (ACC_W+1)'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W:0] SAT_HI    = (ACC_W+1)'((1 << (ELEM_BITS - 1)) - 1);
    localparam logic signed [ACC_W:0] SAT_LO    = -SAT_HI - (ACC_W+1)'(1);

    t_mac_ctl                      r_ctl;
    logic signed [2*ELEM_BITS-1:0] r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_done;
    logic signed [ACC_W:0]         w_rounded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_done <= r_ctl.valid && r_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= i_a * i_b;
        end
        if (r_ctl.valid) begin
            if (r_ctl.first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // Adding half an LSB and flooring rounds half toward plus infinity.
    assign w_rounded = ((ACC_W+1)'(r_acc) + ROUND_ADD) >>> FRAC_BITS;

    always_comb begin
        if (w_rounded > SAT_HI) begin
            o_result = ELEM_BITS'(SAT_HI);
        end else if (w_rounded < SAT_LO) begin
            o_result = ELEM_BITS'(SAT_LO);
        end else begin
            o_result = ELEM_BITS'(w_rounded);
        end
    end

    assign o_done = r_done;

endmodule

// ===== hw/rtl/matrix_multiply_core.sv =====
// Matrix multiply core: element stores, sequencer and output register around one MAC unit.
//
//  Channel  Dir  tdata (low bit up)                          tuser / tlast
//  s        in   row_index, col_index, element_value, pad    tuser: func
//  m        out  product_value, out_row, out_col, pad        tuser: size_mismatch, tlast: last
//  cfg      in   write enable, index, 4-bit value            -
//
// A load beat is taken while idle. A compute beat keeps the input side not
// ready while it walks the result: each element issues a MAC per inner index
// up to a_cols, then waits for read, multiply, accumulate and hand-off on the
// shared multiplier. On a size mismatch each element is a zero product with
// no MAC issue. Reset is synchronous; stores are not cleared. A stalled
// output holds its beat and the next element is computed behind it.
module matrix_multiply_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [23:0]                       i_s_tdata,  // row_index, col_index, element_value
    input  logic [1:0]                        i_s_tuser,  // func
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [23:0]                       o_m_tdata,  // product_value, out_row, out_col
    output logic                              o_m_tuser,  // size_mismatch
    output logic                              o_m_tlast,  // last
    input  logic                              i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mm_pkg::DIM_W-1:0]          i_cfg_data
);
    import mm_pkg::*;

    logic [DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_row, n_row, r_col, n_col, r_k, n_k;
    logic [IDX_W-1:0]  r_rmax, n_rmax, r_cmax, n_cmax, r_kmax, n_kmax;
    logic              r_mis, n_mis;
    t_mac_ctl          r_iss, n_iss;
    logic              w_emit;

    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_out_val;
    logic [PORT_IDX_W-1:0] r_out_row, r_out_col;
    logic                  r_out_last, r_out_mis;

    logic [PORT_IDX_W-1:0]       w_in_row, w_in_col;
    logic signed [ELEM_BITS-1:0] w_in_val;
    logic                        w_accept, w_in_range, w_we_a, w_we_b;
    logic [ADDR_W-1:0]           w_waddr, w_raddr_a, w_raddr_b;
    logic signed [ELEM_BITS-1:0] w_rd_a, w_rd_b, w_mac_res;
    logic                        w_mac_done, w_last_elem, w_out_free;

    assign w_in_row   = i_s_tdata[2:0];
    assign w_in_col   = i_s_tdata[5:3];
    assign w_in_val   = i_s_tdata[6 +: ELEM_BITS];
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_in_range = (int'(w_in_row) < MAX_DIM) && (int'(w_in_col) < MAX_DIM);
    assign w_waddr    = addr_of(IDX_W'(w_in_row), IDX_W'(w_in_col));
    assign w_we_a     = w_accept && w_in_range && (t_func'(i_s_tuser) == FUNC_LOAD_A);
    assign w_we_b     = w_accept && w_in_range && (t_func'(i_s_tuser) == FUNC_LOAD_B);
    assign w_raddr_a  = addr_of(r_row, r_k);
    assign w_raddr_b  = addr_of(r_k, r_col);
    assign w_last_elem = (r_row == r_rmax) && (r_col == r_cmax);
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= DIM_W'(1);
            r_a_cols <= DIM_W'(1);
            r_b_rows <= DIM_W'(1);
            r_b_cols <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_A_ROWS: r_a_rows <= i_cfg_data;
                CFG_A_COLS: r_a_cols <= i_cfg_data;
                CFG_B_ROWS: r_b_rows <= i_cfg_data;
                CFG_B_COLS: r_b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mm_store u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_in_val),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rd_a)
    );

    mm_store u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_in_val),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rd_b)
    );

    // The issue tag is registered to line up with the registered store reads.
    mm_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_iss),
        .i_a      (w_rd_a),
        .i_b      (w_rd_b),
        .o_done   (w_mac_done),
        .o_result (w_mac_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iss   <= '0;
        end else begin
            r_state <= n_state;
            r_iss   <= n_iss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_k    <= n_k;
        r_rmax <= n_rmax;
        r_cmax <= n_cmax;
        r_kmax <= n_kmax;
        r_mis  <= n_mis;
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;
        n_rmax  = r_rmax;
        n_cmax  = r_cmax;
        n_kmax  = r_kmax;
        n_mis   = r_mis;
        n_iss   = '0;
        w_emit  = 1'b0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid && (t_func'(i_s_tuser) == FUNC_COMPUTE)) begin
                    n_rmax = dim_max(r_a_rows);
                    n_cmax = dim_max(r_b_cols);
                    n_kmax = dim_max(r_a_cols);
                    n_mis  = dim_max(r_a_cols) != dim_max(r_b_rows);
                    n_row  = '0;
                    n_col  = '0;
                    n_k    = '0;
                    n_state = n_mis ? S_EMIT : S_MAC;
                end
            end
            S_MAC: begin
                n_iss.valid = 1'b1;
                n_iss.first = (r_k == '0);
                n_iss.last  = (r_k == r_kmax);
                if (r_k == r_kmax) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (w_mac_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    n_k    = '0;
                    if (w_last_elem) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = r_mis ? S_EMIT : S_MAC;
                        if (r_col == r_cmax) begin
                            n_col = '0;
                            n_row = r_row + IDX_W'(1);
                        end else begin
                            n_col = r_col + IDX_W'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_val  <= r_mis ? '0 : VAL_W'(w_mac_res);
            r_out_row  <= PORT_IDX_W'(r_row);
            r_out_col  <= PORT_IDX_W'(r_col);
            r_out_last <= w_last_elem;
            r_out_mis  <= r_mis;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_col, r_out_row, r_out_val};
    assign o_m_tuser  = r_out_mis;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== hw/rtl/mm_checker.sv =====
// Port-level checks for the matrix multiply core, bound to the top level.
module mm_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         o_s_tready,
    input  logic [1:0]                   i_s_tuser,
    input  logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [23:0]                  o_m_tdata,
    input  logic                         o_m_tuser,
    input  logic                         o_m_tlast
);
    import mm_pkg::*;

    logic w_load, w_compute;
    assign w_load    = i_s_tvalid && o_s_tready &&
                       ((i_s_tuser == FUNC_LOAD_A) || (i_s_tuser == FUNC_LOAD_B));
    assign w_compute = i_s_tvalid && o_s_tready && (i_s_tuser == FUNC_COMPUTE);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output beat changed while stalled");

    a_mismatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[15:0] == 16'd0)
        else $error("mismatch beat carries a nonzero product");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_compute |=> !o_s_tready)
        else $error("input ready right after a compute beat");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_s_tready)
        else $error("load beat stalled the input side");

endmodule

bind matrix_multiply_core mm_checker u_mm_checker (.*);
